// File: rtl/rlcc_pkg.sv
// Package for the RGBC lux and color temperature unit.
// Holds the fixed-point coefficients, widths and the gain lookup.
// No dependencies.
`timescale 1ns / 1ps

package rlcc_pkg;

  // Q16 coefficients of the lux sum, rounded to nearest.
  localparam int unsigned CoefRQ16 = 8913;
  localparam int unsigned CoefGQ16 = 65536;
  localparam int unsigned CoefBQ16 = 29098;
  localparam int unsigned TwoP4Q16 = 157286;

  // Device factor 310 times 8 for the four fractional output bits.
  localparam int unsigned LuxScale = 2480;

  // Color temperature slope and offset.
  localparam int unsigned CtCoef   = 3810;
  localparam int unsigned CtOffset = 1391;

  // Quotient bits produced by each division chain.
  localparam int unsigned QuoWidth = 30;

  // Divisor widths of the two chains.
  localparam int unsigned LuxDenWidth = 32;
  localparam int unsigned CctDenWidth = 17;

  // Gain code to gain multiplier.
  localparam logic [1:0] Gain1x  = 2'd0;
  localparam logic [1:0] Gain4x  = 2'd1;
  localparam logic [1:0] Gain16x = 2'd2;
  localparam logic [1:0] Gain60x = 2'd3;

  function automatic logic [5:0] gain_mult(input logic [1:0] code);
    logic [5:0] m;
    case (code)
      Gain1x:  m = 6'd1;
      Gain4x:  m = 6'd4;
      Gain16x: m = 6'd16;
      Gain60x: m = 6'd60;
      default: m = 6'd1;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/rlcc_div_cell.sv
// One restoring division step: produces one quotient bit per cycle.
// Carries the divisor and a side payload to the next cell of the chain.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module rlcc_div_cell #(
  parameter int unsigned RW = 32,
  parameter int unsigned QW = 30,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] quo_in,
  input  logic [RW-1:0] den_in,
  input  logic [SW-1:0] side_in,
  output logic [RW-1:0] rem_out,
  output logic [QW-1:0] quo_out,
  output logic [RW-1:0] den_out,
  output logic [SW-1:0] side_out
);

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  // Shift in the next dividend bit and try subtracting the divisor.
  always_comb begin
    trial    = {rem_in, quo_in[QW-1]};
    diff     = trial - {1'b0, den_in};
    ge       = (trial >= {1'b0, den_in});
    rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
    quo_next = {quo_in[QW-2:0], ge};
  end

  // Hand the step result to the neighbor.
  always_ff @(posedge clk) begin
    rem_out  <= rem_next;
    quo_out  <= quo_next;
    den_out  <= den_in;
  end

  // The side payload carries the valid flag, so it is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule

// File: rtl/rlcc_div_chain.sv
// Row of division cells that turns a dividend into a quotient, one bit per cell.
// Depends on rlcc_div_cell.
`timescale 1ns / 1ps

module rlcc_div_chain #(
  parameter int unsigned RW = 32,
  parameter int unsigned QW = 30,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] quo_in,
  input  logic [RW-1:0] den_in,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo_out,
  output logic [SW-1:0] side_out
);

  logic [RW-1:0] rem_w  [0:QW];
  logic [QW-1:0] quo_w  [0:QW];
  logic [RW-1:0] den_w  [0:QW];
  logic [SW-1:0] side_w [0:QW];

  assign rem_w[0]  = rem_in;
  assign quo_w[0]  = quo_in;
  assign den_w[0]  = den_in;
  assign side_w[0] = side_in;

  // One cell per quotient bit.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    rlcc_div_cell #(.RW(RW), .QW(QW), .SW(SW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .rem_in  (rem_w[i]),
      .quo_in  (quo_w[i]),
      .den_in  (den_w[i]),
      .side_in (side_w[i]),
      .rem_out (rem_w[i+1]),
      .quo_out (quo_w[i+1]),
      .den_out (den_w[i+1]),
      .side_out(side_w[i+1])
    );
  end

  assign quo_out  = quo_w[QW];
  assign side_out = side_w[QW];

endmodule

// File: rtl/rgbc_lux_cct_calc_unit.sv
// Throughput: one transaction per cycle; busy is never raised.
// Three setup stages feed two rows of 30 division cells, one quotient bit per cell.
// Synchronous active-high reset clears the valid flags; no results follow it.
// Results are shown for one cycle with done; the receiver cannot stall them.
// Depends on rlcc_pkg and rlcc_div_chain.
`timescale 1ns / 1ps

module rgbc_lux_cct_calc_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_count,
  input  logic [15:0] green_count,
  input  logic [15:0] blue_count,
  input  logic [15:0] clear_count,
  input  logic [7:0]  atime_byte,
  input  logic [1:0]  gain_code,
  output logic        done,
  output logic [29:0] lux_value,
  output logic [15:0] color_temp,
  output logic        cct_invalid
);

  localparam int unsigned QW  = rlcc_pkg::QuoWidth;
  localparam int unsigned LRW = rlcc_pkg::LuxDenWidth;
  localparam int unsigned CRW = rlcc_pkg::CctDenWidth;

  // Stage 1: IR-corrected doubled colors, cycles and gain.
  logic               v1;
  logic signed [18:0] r2, g2, b2;
  logic [8:0]         cyc;
  logic [5:0]         gmul;

  // Stage 2: products.
  logic               v2;
  logic signed [35:0] acc;
  logic [14:0]        cg;
  logic signed [31:0] nct;
  logic signed [18:0] r2_d;

  // Stage 3: dividends and divisors.
  logic               v3;
  logic [44:0]        num;
  logic [31:0]        den;
  logic [29:0]        cnum;
  logic [16:0]        cden;
  logic               inv3;
  logic               neg3;

  logic               accept;
  logic [33:0]        mag;
  logic signed [31:0] nfix;
  logic [18:0]        dabs;

  logic [QW-1:0]      lux_q;
  logic [QW-1:0]      cct_q;
  logic               lux_v;
  logic [1:0]         cct_side;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid flags through the setup stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Remove the infrared part: 2X' = X - others + clear.
  always_ff @(posedge clk) begin
    r2   <= $signed({3'b000, red_count}) - $signed({3'b000, green_count})
          - $signed({3'b000, blue_count}) + $signed({3'b000, clear_count});
    g2   <= $signed({3'b000, green_count}) - $signed({3'b000, red_count})
          - $signed({3'b000, blue_count}) + $signed({3'b000, clear_count});
    b2   <= $signed({3'b000, blue_count}) - $signed({3'b000, red_count})
          - $signed({3'b000, green_count}) + $signed({3'b000, clear_count});
    cyc  <= 9'd256 - {1'b0, atime_byte};
    gmul <= rlcc_pkg::gain_mult(gain_code);
  end

  // Weighted lux sum, cycle-gain product and color temperature numerator.
  always_ff @(posedge clk) begin
    acc  <= 36'(r2) * 36'(rlcc_pkg::CoefRQ16) + 36'(g2) * 36'(rlcc_pkg::CoefGQ16)
          - 36'(b2) * 36'(rlcc_pkg::CoefBQ16);
    cg   <= 15'(cyc) * 15'(gmul);
    nct  <= 32'(b2) * 32'(rlcc_pkg::CtCoef) + 32'(r2) * 32'(rlcc_pkg::CtOffset);
    r2_d <= r2;
  end

  // Magnitudes and sign handling before the division rows.
  always_comb begin
    mag  = acc[35] ? 34'(-acc) : 34'(acc);
    nfix = r2_d[18] ? -nct : nct;
    dabs = r2_d[18] ? 19'(-r2_d) : 19'(r2_d);
  end

  always_ff @(posedge clk) begin
    num  <= 45'(mag) * 45'(rlcc_pkg::LuxScale);
    den  <= 32'(cg) * 32'(rlcc_pkg::TwoP4Q16);
    cnum <= nfix[31] ? '0 : nfix[29:0];
    cden <= dabs[16:0];
    inv3 <= (r2_d == '0);
    neg3 <= nfix[31];
  end

  // Lux division: the upper dividend bits already lie below the divisor.
  rlcc_div_chain #(.RW(LRW), .QW(QW), .SW(1)) u_lux_chain (
    .clk     (clk),
    .rst     (rst),
    .rem_in  (LRW'(num[44:QW])),
    .quo_in  (num[QW-1:0]),
    .den_in  (den),
    .side_in (v3 && !rst),
    .quo_out (lux_q),
    .side_out(lux_v)
  );

  // Color temperature division, carrying the invalid and negative flags.
  rlcc_div_chain #(.RW(CRW), .QW(QW), .SW(2)) u_cct_chain (
    .clk     (clk),
    .rst     (rst),
    .rem_in  ('0),
    .quo_in  (cnum),
    .den_in  (cden),
    .side_in ({inv3, neg3}),
    .quo_out (cct_q),
    .side_out(cct_side)
  );

  // Result register with clamping of the color temperature.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lux_v;
    end
    lux_value   <= lux_q;
    cct_invalid <= cct_side[1];
    if (cct_side[1] || cct_side[0]) begin
      color_temp <= '0;
    end else if (cct_q[QW-1:16] != '0) begin
      color_temp <= 16'hFFFF;
    end else begin
      color_temp <= cct_q[15:0];
    end
  end

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    done && cct_invalid |-> color_temp == 16'd0)
    else $error("invalid color temperature is not zero");

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result after reset");

  a_accept_v1: assert property (@(posedge clk) disable iff (rst)
    start |=> v1)
    else $error("accepted transaction lost at first stage");

endmodule

// File: dv/rgbc_lux_cct_calc_unit_checker.sv
// Checker for the RGBC lux and color temperature unit: predicts each result
// from the accepted samples and compares it with what the block reports.
// Depends on rlcc_pkg for the gain codes.
`timescale 1ns / 1ps

module rgbc_lux_cct_calc_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] red_count,
  input  logic [15:0] green_count,
  input  logic [15:0] blue_count,
  input  logic [15:0] clear_count,
  input  logic [7:0]  atime_byte,
  input  logic [1:0]  gain_code,
  input  logic        done,
  input  logic [29:0] lux_value,
  input  logic [15:0] color_temp,
  input  logic        cct_invalid,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [29:0] lux;
    logic [15:0] cct;
    logic        invalid;
  } light_result_t;

  light_result_t light_q[$];

  // Gain multiplier for one code.
  function automatic longint gain_of(input logic [1:0] code);
    longint m;
    case (code)
      rlcc_pkg::Gain1x:  m = 1;
      rlcc_pkg::Gain4x:  m = 4;
      rlcc_pkg::Gain16x: m = 16;
      default: m = 60;
    endcase
    return m;
  endfunction

  // Illuminance and color temperature of one sample, exact in 64 bits.
  function automatic light_result_t compute_light(
      input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
      input logic [15:0] c, input logic [7:0] atime, input logic [1:0] gcode);
    light_result_t res;
    longint sum, r2, g2, b2, acc, num, den, lux, n, d, q;
    sum = longint'(r) + longint'(g) + longint'(b) - longint'(c);
    r2  = 2 * longint'(r) - sum;
    g2  = 2 * longint'(g) - sum;
    b2  = 2 * longint'(b) - sum;
    acc = 8913 * r2 + 65536 * g2 - 29098 * b2;
    if (acc < 0) acc = -acc;
    num = acc * 2480;
    den = (256 - longint'(atime)) * gain_of(gcode) * 157286;
    lux = num / den;
    if (lux > 1073741823) lux = 1073741823;
    res.lux = lux[29:0];
    res.cct = '0;
    res.invalid = 1'b0;
    if (r2 == 0) begin
      res.invalid = 1'b1;
    end else begin
      n = 3810 * b2 + 1391 * r2;
      d = r2;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      q = n / d;
      if (q < 0) q = 0;
      if (q > 65535) q = 65535;
      res.cct = q[15:0];
    end
    return res;
  endfunction

  assign pending = light_q.size();

  // Record accepted samples and check every reported result.
  always @(posedge clk) begin
    light_result_t want;
    if (rst) begin
      fail_count <= 0;
      light_q.delete();
    end else begin
      if (start && !busy)
        light_q.push_back(compute_light(red_count, green_count, blue_count,
                                        clear_count, atime_byte, gain_code));
      if (done) begin
        if (light_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          want = light_q.pop_front();
          if (want.lux !== lux_value || want.cct !== color_temp ||
              want.invalid !== cct_invalid) begin
            if (fail_count < 10)
              $display("mismatch: lux %0d/%0d cct %0d/%0d invalid %0d/%0d (exp/act)",
                       want.lux, lux_value, want.cct, color_temp,
                       want.invalid, cct_invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

// File: dv/rgbc_lux_cct_calc_unit_test.sv
// Top of the testbench: drives directed and random sensor samples into the
// unit and gives the verdict. Depends on the unit and its checker.
`timescale 1ns / 1ps

module rgbc_lux_cct_calc_unit_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] red_count = '0, green_count = '0, blue_count = '0, clear_count = '0;
  logic [7:0]  atime_byte = '0;
  logic [1:0]  gain_code = rlcc_pkg::Gain1x;
  logic        done;
  logic [29:0] lux_value;
  logic [15:0] color_temp;
  logic        cct_invalid;
  int          fail_count, pending;
  int          cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgbc_lux_cct_calc_unit u_dut (.*);
  rgbc_lux_cct_calc_unit_checker u_chk (.*);

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("rgbc_lux_cct_calc_unit test failed");
      $finish;
    end
  end

  // Send one sample after a random gap and wait until it is accepted.
  task automatic send_sample(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic [15:0] c,
                             input logic [7:0] atime, input logic [1:0] gcode);
    int gap;
    logic was_busy;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    red_count   <= r;
    green_count <= g;
    blue_count  <= b;
    clear_count <= c;
    atime_byte  <= atime;
    gain_code   <= gcode;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
  endtask

  // Random count biased toward the ends of its range.
  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [15:0] v;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every gain, zero corrected red, sign and clamp cases.
    send_sample(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, rlcc_pkg::Gain1x);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, rlcc_pkg::Gain60x);
    send_sample(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd255, rlcc_pkg::Gain1x);
    send_sample(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd0, rlcc_pkg::Gain60x);
    send_sample(16'd1000, 16'd2000, 16'd1500, 16'd4000, 8'd192, rlcc_pkg::Gain4x);
    send_sample(16'd1000, 16'd2000, 16'd1500, 16'd4000, 8'd192, rlcc_pkg::Gain16x);
    send_sample(16'd500, 16'd500, 16'd500, 16'd500, 8'd100, rlcc_pkg::Gain4x);
    send_sample(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd255, rlcc_pkg::Gain1x);
    send_sample(16'd1, 16'd0, 16'd0, 16'd0, 8'd10, rlcc_pkg::Gain16x);
    send_sample(16'd0, 16'd0, 16'd59999, 16'd60000, 8'd200, rlcc_pkg::Gain4x);
    send_sample(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'd255, rlcc_pkg::Gain1x);
    send_sample(16'd0, 16'd0, 16'hFFFF, 16'd0, 8'd255, rlcc_pkg::Gain1x);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA, rlcc_pkg::Gain16x);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, rlcc_pkg::Gain4x);

    // Random samples; some with equal counts so that corrected red is zero.
    for (int i = 0; i < 600; i++) begin
      if (i == 300) begin
        // Drain the pipeline before going on.
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        v = pick_count();
        send_sample(v, v, v, v, 8'($urandom()), 2'($urandom()));
      end else begin
        send_sample(pick_count(), pick_count(), pick_count(), pick_count(),
                    ($urandom_range(0, 3) == 0) ? 8'(255 * $urandom_range(0, 1))
                                                 : 8'($urandom()),
                    2'($urandom()));
      end
    end
    start <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rgbc_lux_cct_calc_unit test passed");
    end else begin
      $display("rgbc_lux_cct_calc_unit test failed");
    end
    $finish;
  end
endmodule
